/* sv/swv_pkg.sv */
package swv_pkg;

  // Register indexes of the configuration port
  localparam logic [1:0] CFG_SWEEP_MINIMUM       = 2'd0;
  localparam logic [1:0] CFG_SWEEP_MAXIMUM       = 2'd1;
  localparam logic [1:0] CFG_SWEEP_STEP          = 2'd2;
  localparam logic [1:0] CFG_DAMPING_COEFFICIENT = 2'd3;

  // Reset values of the registers
  localparam logic [23:0] SWEEP_MINIMUM_RESET       = 24'd760872;
  localparam logic [23:0] SWEEP_MAXIMUM_RESET       = 24'd1902179;
  localparam logic [15:0] SWEEP_STEP_RESET          = 16'd38;
  localparam logic [15:0] DAMPING_COEFFICIENT_RESET = 16'd1638;

  // Position fold point (one half in Q0.24) and its full-scale limit
  localparam logic [23:0] POS_HALF = 24'h800000;
  localparam logic [23:0] POS_MAX  = 24'hFFFFFF;

  // Sine table generation constants, Q2.30
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_D,
    ST_HIGH,
    ST_MUL_FH,
    ST_BAND,
    ST_MUL_FB,
    ST_LOW,
    ST_DONE
  } state_t;

  // Operand pairs of the shared multiplier
  typedef enum logic [1:0] {
    MUL_DAMP_BAND,
    MUL_F_HIGH,
    MUL_F_BAND
  } mul_sel_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic     load_x;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     load_high;
    logic     load_band;
    logic     load_low;
    logic     finish;
  } cmd_t;

  // Saturate a 37-bit signed sum to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
    logic signed [31:0] r;
    if (v[36:31] == 6'b000000 || v[36:31] == 6'b111111) begin
      r = v[31:0];
    end else if (v[36]) begin
      r = 32'sh80000000;
    end else begin
      r = 32'sh7FFFFFFF;
    end
    return r;
  endfunction

  // One sine table entry: 2*sin(x) in Q2.14 from angle x in Q2.30,
  // integer Taylor series in Horner form, rounded half up
  function automatic logic [15:0] sine_entry(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] r;
    x2 = (x * x) >> 30;
    t  = ONE_Q30;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd156;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd110;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
    s  = (x * t) >> 30;
    r  = (s + (64'd1 << 14)) >> 15;
    return r[15:0];
  endfunction

endpackage

/* sv/swept_state_variable_wah_top.sv */
// Channel   Handshake              Payload
// input     in_valid / in_ready    audio_in (s16)
// output    out_valid / out_ready  audio_out (s16), clipped
// config    cfg_write              cfg_index (2), cfg_data (24)
//
// A sample runs through the accept cycle, then three multiply/add-saturate
// pairs on one shared 17x32 multiplier, then the output step.
// Reset (rst, synchronous) loads the register defaults, clears the filter
// state and puts the sweep at its default minimum, rising.
// A stalled result holds in the output register; the next sample runs up to
// its output step and waits there.
module swept_state_variable_wah_top #(
  parameter int SINE_TABLE_DEPTH    = 1024,
  parameter int STATE_FRACTION_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] audio_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] audio_out,
  output logic               clipped,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data
);

  swv_pkg::cmd_t cmd;

  swv_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  swv_datapath #(
    .SINE_TABLE_DEPTH    (SINE_TABLE_DEPTH),
    .STATE_FRACTION_BITS (STATE_FRACTION_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .audio_in  (audio_in),
    .cmd       (cmd),
    .audio_out (audio_out),
    .clipped   (clipped)
  );

`ifndef SYNTHESIS
  // One sample in flight: no transfer right after a transfer
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while a sample is in flight");

  // At most one register-load command per cycle
  a_loads_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load_x, cmd.load_high, cmd.load_band, cmd.load_low, cmd.finish}))
    else $error("overlapping load commands");

  // A result appears only from the output step
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.finish))
    else $error("result valid without output step");

  // A clipped result sits at a rail
  a_clip_rail: assert property (@(posedge clk) disable iff (rst)
    (out_valid && clipped) |-> (audio_out == 16'sh7FFF || audio_out == 16'sh8000))
    else $error("clipped result not at a rail");
`endif

endmodule

/* sv/swv_sine_rom.sv */
module swv_sine_rom #(
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic        clk,
  input  logic [23:0] position,
  output logic [15:0] f
);

  localparam int IW = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int PW = 24 + IW;

  logic [15:0]   rom [SINE_TABLE_DEPTH + 1];
  logic [23:0]   folded;
  logic [PW-1:0] scaled;
  logic [IW:0]   idx_full;
  logic [IW-1:0] idx_next;
  logic [IW-1:0] idx;

  // Build the quarter-wave table at elaboration
  for (genvar i = 0; i <= SINE_TABLE_DEPTH; i++) begin : g_rom
    localparam logic [63:0] X = (swv_pkg::HALF_PI_Q30 * 64'(i)) / 64'(SINE_TABLE_DEPTH);
    assign rom[i] = swv_pkg::sine_entry(X);
  end

  // Fold the upper half by symmetry and scale to a table index
  always_comb begin
    folded   = (position > swv_pkg::POS_HALF) ? 24'(25'h1000000 - 25'(position)) : position;
    scaled   = PW'(folded) * PW'(SINE_TABLE_DEPTH);
    idx_full = scaled[PW-1:23];
    idx_next = (idx_full > (IW + 1)'(SINE_TABLE_DEPTH)) ? IW'(SINE_TABLE_DEPTH)
                                                        : idx_full[IW-1:0];
  end

  // Register the index, then the table read
  always_ff @(posedge clk) begin
    idx <= idx_next;
    f   <= rom[idx];
  end

endmodule

/* sv/swv_ctrl.sv */
module swv_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output swv_pkg::cmd_t  cmd
);

  swv_pkg::state_t state;
  swv_pkg::state_t state_next;
  logic            out_valid_next;
  logic            out_free;

  // State and result-valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= swv_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Refuse transfers while reset is applied
  assign in_ready = (state == swv_pkg::ST_IDLE) && !rst;
  assign out_free = !out_valid || out_ready;

  // Sequence one sample through the shared multiplier
  always_comb begin
    state_next     = state;
    out_valid_next = out_valid && !out_ready;
    cmd            = '0;
    cmd.mul_sel    = swv_pkg::MUL_DAMP_BAND;
    unique case (state)
      swv_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load_x = 1'b1;
          state_next = swv_pkg::ST_MUL_D;
        end
      end
      swv_pkg::ST_MUL_D: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = swv_pkg::MUL_DAMP_BAND;
        state_next  = swv_pkg::ST_HIGH;
      end
      swv_pkg::ST_HIGH: begin
        cmd.load_high = 1'b1;
        state_next    = swv_pkg::ST_MUL_FH;
      end
      swv_pkg::ST_MUL_FH: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = swv_pkg::MUL_F_HIGH;
        state_next  = swv_pkg::ST_BAND;
      end
      swv_pkg::ST_BAND: begin
        cmd.load_band = 1'b1;
        state_next    = swv_pkg::ST_MUL_FB;
      end
      swv_pkg::ST_MUL_FB: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = swv_pkg::MUL_F_BAND;
        state_next  = swv_pkg::ST_LOW;
      end
      swv_pkg::ST_LOW: begin
        cmd.load_low = 1'b1;
        state_next   = swv_pkg::ST_DONE;
      end
      swv_pkg::ST_DONE: begin
        // Hold until the result register is free
        if (out_free) begin
          cmd.finish     = 1'b1;
          out_valid_next = 1'b1;
          state_next     = swv_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = swv_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* sv/swv_datapath.sv */
module swv_datapath #(
  parameter int SINE_TABLE_DEPTH    = 1024,
  parameter int STATE_FRACTION_BITS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [1:0]          cfg_index,
  input  logic [23:0]         cfg_data,
  input  logic signed [15:0]  audio_in,
  input  swv_pkg::cmd_t       cmd,
  output logic signed [15:0]  audio_out,
  output logic                clipped
);

  localparam int XW = 16 + STATE_FRACTION_BITS;

  logic [23:0]        sweep_minimum;
  logic [23:0]        sweep_maximum;
  logic [15:0]        sweep_step;
  logic [15:0]        damping_coefficient;
  logic [23:0]        sweep_position;
  logic               sweep_rising;
  logic signed [31:0] band_state;
  logic signed [31:0] low_state;

  logic signed [XW-1:0] x;
  logic signed [31:0]   high;
  logic signed [48:0]   prod;
  logic [15:0]          f;

  logic signed [16:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [34:0] prod_sh;
  logic signed [36:0] high_sum;
  logic signed [36:0] band_sum;
  logic signed [36:0] low_sum;
  logic signed [31:0] y_full;
  logic [24:0]        pos_sum;
  logic [23:0]        pos_up;
  logic [23:0]        pos_down;
  logic [23:0]        pos_next;
  logic               rising_next;

  swv_sine_rom #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_rom (
    .clk      (clk),
    .position (sweep_position),
    .f        (f)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_minimum       <= swv_pkg::SWEEP_MINIMUM_RESET;
      sweep_maximum       <= swv_pkg::SWEEP_MAXIMUM_RESET;
      sweep_step          <= swv_pkg::SWEEP_STEP_RESET;
      damping_coefficient <= swv_pkg::DAMPING_COEFFICIENT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        swv_pkg::CFG_SWEEP_MINIMUM:       sweep_minimum       <= cfg_data;
        swv_pkg::CFG_SWEEP_MAXIMUM:       sweep_maximum       <= cfg_data;
        swv_pkg::CFG_SWEEP_STEP:          sweep_step          <= cfg_data[15:0];
        swv_pkg::CFG_DAMPING_COEFFICIENT: damping_coefficient <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Select multiplier operands
  always_comb begin
    unique case (cmd.mul_sel)
      swv_pkg::MUL_DAMP_BAND: begin
        mul_a = $signed({1'b0, damping_coefficient});
        mul_b = band_state;
      end
      swv_pkg::MUL_F_HIGH: begin
        mul_a = $signed({1'b0, f});
        mul_b = high;
      end
      swv_pkg::MUL_F_BAND: begin
        mul_a = $signed({1'b0, f});
        mul_b = band_state;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Filter sums; the Q2.14 product drops 14 bits rounding down
  always_comb begin
    prod_sh  = prod[48:14];
    high_sum = 37'(x) - 37'(low_state) - 37'(prod_sh);
    band_sum = 37'(prod_sh) + 37'(band_state);
    low_sum  = 37'(prod_sh) + 37'(low_state);
    y_full   = band_state >>> STATE_FRACTION_BITS;
  end

  // Triangle sweep: step, saturate at the ends, then turn
  always_comb begin
    pos_sum     = {1'b0, sweep_position} + 25'(sweep_step);
    pos_up      = pos_sum[24] ? swv_pkg::POS_MAX : pos_sum[23:0];
    pos_down    = (24'(sweep_step) > sweep_position) ? 24'd0
                                                    : sweep_position - 24'(sweep_step);
    pos_next    = sweep_rising ? pos_up : pos_down;
    rising_next = sweep_rising;
    priority if (pos_next >= sweep_maximum) begin
      rising_next = 1'b0;
    end else if (pos_next <= sweep_minimum) begin
      rising_next = 1'b1;
    end
  end

  // Filter and sweep state
  always_ff @(posedge clk) begin
    if (rst) begin
      band_state     <= '0;
      low_state      <= '0;
      sweep_position <= swv_pkg::SWEEP_MINIMUM_RESET;
      sweep_rising   <= 1'b1;
    end else begin
      if (cmd.load_band) begin
        band_state <= swv_pkg::sat32(band_sum);
      end
      if (cmd.load_low) begin
        low_state <= swv_pkg::sat32(low_sum);
      end
      if (cmd.finish) begin
        sweep_position <= pos_next;
        sweep_rising   <= rising_next;
      end
    end
  end

  // Working registers and the result register
  always_ff @(posedge clk) begin
    if (cmd.load_x) begin
      x <= XW'(audio_in) <<< STATE_FRACTION_BITS;
    end
    if (cmd.mul_en) begin
      prod <= mul_a * mul_b;
    end
    if (cmd.load_high) begin
      high <= swv_pkg::sat32(high_sum);
    end
    if (cmd.finish) begin
      if (y_full[31:15] == '0 || y_full[31:15] == '1) begin
        audio_out <= y_full[15:0];
        clipped   <= 1'b0;
      end else begin
        audio_out <= y_full[31] ? 16'sh8000 : 16'sh7FFF;
        clipped   <= 1'b1;
      end
    end
  end

endmodule

/* dv/wah_band_checker.sv */
module wah_band_checker
  import swv_pkg::*;
#(
  parameter int SINE_TABLE_DEPTH    = 1024,
  parameter int STATE_FRACTION_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [15:0] audio_in,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [15:0] audio_out,
  input  logic               clipped,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  output int                 pending_results,
  output int                 mismatch_count
);

  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;

  typedef struct packed {
    logic signed [15:0] audio;
    logic               clip;
  } wah_out_t;

  // Register copies
  logic [23:0] turn_low;
  logic [23:0] turn_high;
  logic [15:0] sweep_inc;
  logic [15:0] damp_q14;

  // Filter and sweep state
  logic [23:0]        sweep_pos;
  logic               sweep_up;
  logic signed [31:0] band_acc;
  logic signed [31:0] low_acc;

  logic [15:0] sine_tab [0:SINE_TABLE_DEPTH];
  wah_out_t    expected_band [$];
  int          err_total;

  // Build the quarter-wave table of 2*sin in Q2.14
  initial begin
    longint unsigned ang;
    longint unsigned ang_sq;
    longint unsigned term;
    longint unsigned prod;
    longint unsigned divisor [6];
    divisor = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
    for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
      ang    = (HALF_PI_Q30 * longint'(i)) / longint'(SINE_TABLE_DEPTH);
      ang_sq = (ang * ang) >> 30;
      term   = ONE_Q30;
      for (int k = 0; k < 6; k++) begin
        term = ONE_Q30 - ((ang_sq * term) >> 30) / divisor[k];
      end
      prod = (ang * term) >> 30;
      sine_tab[i] = 16'((prod + (64'd1 << 14)) >> 15);
    end
  end

  function automatic longint clamp32(input longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  // Fold the position about one half and index the table
  function automatic longint tuning_coef(input logic [23:0] p);
    logic [24:0]     folded;
    longint unsigned idx;
    folded = (p > POS_HALF) ? (25'h1000000 - {1'b0, p}) : {1'b0, p};
    idx = (longint'(folded) * longint'(SINE_TABLE_DEPTH)) >> 23;
    if (idx > SINE_TABLE_DEPTH) idx = SINE_TABLE_DEPTH;
    return longint'(sine_tab[idx]);
  endfunction

  // Run one sample through the filter, then advance the sweep
  function automatic wah_out_t filter_sample(input logic signed [15:0] sample);
    longint      xs;
    longint      coef;
    longint      hi;
    longint      bd;
    longint      lo;
    longint      y;
    logic [24:0] sum;
    wah_out_t    r;
    xs   = longint'(sample) * (longint'(1) << STATE_FRACTION_BITS);
    coef = tuning_coef(sweep_pos);
    hi = clamp32(xs - longint'(low_acc)
                 - ((longint'(damp_q14) * longint'(band_acc)) >>> 14));
    bd = clamp32(((coef * hi) >>> 14) + longint'(band_acc));
    lo = clamp32(((coef * bd) >>> 14) + longint'(low_acc));
    band_acc = 32'(bd);
    low_acc  = 32'(lo);

    y      = bd >>> STATE_FRACTION_BITS;
    r.clip = 1'b0;
    if (y > 32767) begin
      y      = 32767;
      r.clip = 1'b1;
    end
    if (y < -32768) begin
      y      = -32768;
      r.clip = 1'b1;
    end
    r.audio = 16'(y);

    // Triangle sweep, saturating at both ends of 24 bits
    if (sweep_up) begin
      sum       = {1'b0, sweep_pos} + {9'd0, sweep_inc};
      sweep_pos = sum[24] ? POS_MAX : sum[23:0];
    end else begin
      sweep_pos = ({8'd0, sweep_inc} > sweep_pos) ? 24'd0 : sweep_pos - {8'd0, sweep_inc};
    end
    if (sweep_pos >= turn_high) begin
      sweep_up = 1'b0;
    end else if (sweep_pos <= turn_low) begin
      sweep_up = 1'b1;
    end
    return r;
  endfunction

  // Track registers, predict on input transfer, compare on output transfer
  always @(posedge clk) begin
    wah_out_t exp_res;
    if (rst) begin
      turn_low  = SWEEP_MINIMUM_RESET;
      turn_high = SWEEP_MAXIMUM_RESET;
      sweep_inc = SWEEP_STEP_RESET;
      damp_q14  = DAMPING_COEFFICIENT_RESET;
      sweep_pos = SWEEP_MINIMUM_RESET;
      sweep_up  = 1'b1;
      band_acc  = '0;
      low_acc   = '0;
      expected_band.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_band.size() == 0) begin
          err_total++;
          if (err_total <= 10)
            $display("%0t: unexpected result audio_out %0d clipped %0b",
                     $time, audio_out, clipped);
        end else begin
          exp_res = expected_band.pop_front();
          if (audio_out !== exp_res.audio || clipped !== exp_res.clip) begin
            err_total++;
            if (err_total <= 10)
              $display("%0t: mismatch, expected audio_out %0d clipped %0b, got %0d %0b",
                       $time, exp_res.audio, exp_res.clip, audio_out, clipped);
          end
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          CFG_SWEEP_MINIMUM:       turn_low  = cfg_data;
          CFG_SWEEP_MAXIMUM:       turn_high = cfg_data;
          CFG_SWEEP_STEP:          sweep_inc = cfg_data[15:0];
          CFG_DAMPING_COEFFICIENT: damp_q14  = cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        expected_band.push_back(filter_sample(audio_in));
      end
    end
    pending_results <= expected_band.size();
    mismatch_count  <= err_total;
  end

endmodule

/* dv/tb_swept_state_variable_wah_top.sv */
module tb_swept_state_variable_wah_top;
  import swv_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 500000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [15:0] audio_in = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [15:0] audio_out;
  logic               clipped;
  logic               cfg_write = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [23:0]        cfg_data = '0;

  int   pending_results;
  int   mismatch_count;
  int   cycles = 0;
  logic idle_on = 1'b1;
  logic hold_req = 1'b0;
  logic hold_taken = 1'b0;

  swept_state_variable_wah_top u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .audio_in  (audio_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .audio_out (audio_out),
    .clipped   (clipped),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  wah_band_checker u_check (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .audio_in        (audio_in),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .audio_out       (audio_out),
    .clipped         (clipped),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .pending_results (pending_results),
    .mismatch_count  (mismatch_count)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 4))
          0: return 16'sh7FFF;
          1: return 16'sh8000;
          2: return 16'sh0000;
          3: return 16'shFFFF;
          default: return 16'sh0001;
        endcase
      end
      1, 2: return 16'(int'($urandom_range(0, 511)) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  // Offer one sample and hold it until the transfer
  task automatic send_sample(input logic signed [15:0] s);
    int gap;
    gap = idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    audio_in <= s;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop offering and wait until every result has been taken
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // Load all four registers; upper data bits of the 16-bit ones are junk
  task automatic configure(input logic [23:0] lo, input logic [23:0] hi,
                           input logic [15:0] inc, input logic [15:0] damp);
    write_reg(CFG_SWEEP_MINIMUM, lo);
    write_reg(CFG_SWEEP_MAXIMUM, hi);
    write_reg(CFG_SWEEP_STEP, {8'($urandom), inc});
    write_reg(CFG_DAMPING_COEFFICIENT, {8'($urandom), damp});
  endtask

  task automatic send_random(input int count, input logic with_pressure);
    for (int i = 0; i < count; i++) begin
      if (with_pressure && i == 30) hold_req = 1'b1;
      if (with_pressure && i == 120) drain();
      send_sample(pick_sample());
    end
  endtask

  // Result side: random stalls plus one long hold-off on request
  initial begin
    int gap;
    forever begin
      if (hold_req && !hold_taken) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_taken = 1'b1;
      end else begin
        gap = idle_on ? pick_gap() : 0;
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end else begin
          out_ready <= 1'b1;
          @(posedge clk);
        end
      end
    end
  end

  // Watchdog
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    logic signed [15:0] directed [0:23];
    directed = '{16'sh0000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000,
                 16'sh8000, 16'sh8000, 16'sh8000, 16'sh0000, 16'sh0001, 16'shFFFF,
                 16'sh5555, 16'shAAAA, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000,
                 16'sh0100, 16'shFF00, 16'sh4000, 16'shC000, 16'sh0000, 16'sh0000};
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: steps, extremes and alternation
    foreach (directed[k]) send_sample(directed[k]);
    drain();

    // Full sweep range, fastest step, no damping: hits both position limits
    configure(24'd0, POS_MAX, 16'hFFFF, 16'd0);
    send_random(520, 1'b0);
    drain();

    // Minimum above maximum, damping 2.0
    configure(24'hC00000, 24'h100000, 16'd4000, 16'd32768);
    send_random(150, 1'b0);
    drain();

    // Sweep across the fold point, largest damping, no idling
    idle_on = 1'b0;
    configure(24'h7F0000, 24'h810000, 16'd300, 16'hFFFF);
    send_random(150, 1'b0);
    drain();
    idle_on = 1'b1;

    // Frozen sweep, near-zero damping
    configure(24'd0, 24'd0, 16'd0, 16'd1);
    send_random(150, 1'b0);
    drain();

    // Back to defaults, with a long result stall and a mid-run pause
    configure(SWEEP_MINIMUM_RESET, SWEEP_MAXIMUM_RESET, SWEEP_STEP_RESET,
              DAMPING_COEFFICIENT_RESET);
    send_random(230, 1'b1);
    drain();

    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* swept_state_variable_wah_top.f */
sv/swv_pkg.sv
sv/swv_sine_rom.sv
sv/swv_ctrl.sv
sv/swv_datapath.sv
sv/swept_state_variable_wah_top.sv
dv/wah_band_checker.sv
dv/tb_swept_state_variable_wah_top.sv
